// File: hw/rtl/qirv_pkg.sv
package qirv_pkg;

    localparam int NUM_AXES  = 3;
    localparam int NUM_PAIRS = 10;
    localparam int NUM_TERMS = 6;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // quaternion pair products: w*w, w*q[a], q[a]*q[a], then the three cross pairs
    localparam int PAIR_WW = 0;
    localparam int PAIR_WX = 1;
    localparam int PAIR_XX = 4;
    localparam int PAIR_XY = 7;
    localparam int PAIR_XZ = 8;
    localparam int PAIR_YZ = 9;

    // per-axis product terms; the cross term that is subtracted is paired with the scale term
    localparam int TERM_SCALE     = 0;
    localparam int TERM_CROSS_SUB = 1;
    localparam int TERM_CROSS_ADD = 2;
    localparam int TERM_DOT       = 3;

    function automatic int qq_pair(input int a, input int b);
        if (a == b)
        begin
            return PAIR_XX + a;
        end
        else if (a + b == 1)
        begin
            return PAIR_XY;
        end
        else if (a + b == 2)
        begin
            return PAIR_XZ;
        end
        else
        begin
            return PAIR_YZ;
        end
    endfunction

endpackage

// File: hw/rtl/qirv_if.sv
interface qirv_sample_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

interface qirv_result_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic                         saturated;

    modport source (
        output valid, out_x, out_y, out_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, saturated,
        output ready
    );
endinterface

// File: hw/rtl/qirv_pair_mul.sv
module qirv_pair_mul
    import qirv_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    qirv_sample_if.sink                             sample,
    output logic                                    valid,
    input  logic                                    ready,
    output logic [NUM_PAIRS-1:0][2*DATA_WIDTH-1:0] pairs,
    output logic [NUM_AXES-1:0][DATA_WIDTH-1:0]    vec
);

    logic signed [DATA_WIDTH-1:0]            quat [NUM_AXES];
    logic [NUM_PAIRS-1:0][2*DATA_WIDTH-1:0] pairs_next;
    logic [NUM_PAIRS-1:0][2*DATA_WIDTH-1:0] pairs_reg;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0]    vec_next;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0]    vec_reg;
    logic                                    valid_reg;
    logic                                    load;

    assign quat[AXIS_X] = sample.quat_x;
    assign quat[AXIS_Y] = sample.quat_y;
    assign quat[AXIS_Z] = sample.quat_z;

    assign vec_next[AXIS_X] = sample.vec_x;
    assign vec_next[AXIS_Y] = sample.vec_y;
    assign vec_next[AXIS_Z] = sample.vec_z;

    assign sample.ready = !valid_reg || ready;
    assign load         = sample.valid && sample.ready;

    always_comb
    begin
        pairs_next[PAIR_WW] = sample.quat_w * sample.quat_w;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            pairs_next[PAIR_WX + a] = sample.quat_w * quat[a];
            for (int b = a; b < NUM_AXES; b++)
            begin
                pairs_next[qq_pair(a, b)] = quat[a] * quat[b];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pairs_reg <= pairs_next;
            vec_reg   <= vec_next;
        end
    end

    assign valid = valid_reg;
    assign pairs = pairs_reg;
    assign vec   = vec_reg;

endmodule

// File: hw/rtl/qirv_vec_mul.sv
module qirv_vec_mul
    import qirv_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   up_valid,
    output logic                                                   up_ready,
    input  logic [NUM_PAIRS-1:0][2*DATA_WIDTH-1:0]                pairs,
    input  logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   vec,
    output logic                                                   valid,
    input  logic                                                   ready,
    output logic [NUM_AXES-1:0][NUM_TERMS-1:0][3*DATA_WIDTH-1:0] terms,
    output logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   vec_out
);

    localparam int PROD_W = 3 * DATA_WIDTH;

    logic [NUM_AXES-1:0][DATA_WIDTH-1:0] vec_reg;
    logic                                 valid_reg;
    logic                                 load;

    assign up_ready = !valid_reg || ready;
    assign load     = up_valid && up_ready;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        localparam int J = (a + 1) % NUM_AXES;
        localparam int K = (a + 2) % NUM_AXES;

        logic [NUM_TERMS-1:0][PROD_W-1:0] t_next;
        logic [NUM_TERMS-1:0][PROD_W-1:0] t_reg;

        always_comb
        begin
            t_next[TERM_SCALE]     = $signed(pairs[PAIR_WW]) * $signed(vec[a]);
            t_next[TERM_CROSS_SUB] = $signed(pairs[PAIR_WX + J]) * $signed(vec[K]);
            t_next[TERM_CROSS_ADD] = $signed(pairs[PAIR_WX + K]) * $signed(vec[J]);
            for (int m = 0; m < NUM_AXES; m++)
            begin
                t_next[TERM_DOT + m] = $signed(pairs[qq_pair(a, m)]) * $signed(vec[m]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                t_reg <= t_next;
            end
        end

        assign terms[a] = t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vec_reg <= vec;
        end
    end

    assign valid   = valid_reg;
    assign vec_out = vec_reg;

endmodule

// File: hw/rtl/qirv_sum.sv
module qirv_sum
    import qirv_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)
(
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   up_valid,
    output logic                                                   up_ready,
    input  logic [NUM_AXES-1:0][NUM_TERMS-1:0][3*DATA_WIDTH-1:0] terms,
    input  logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   vec,
    output logic                                                   valid,
    input  logic                                                   ready,
    output logic [NUM_AXES-1:0][3*DATA_WIDTH+2:0]                 total,
    output logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   vec_out
);

    localparam int PROD_W = 3 * DATA_WIDTH;
    localparam int PART_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;

    logic [NUM_AXES-1:0][DATA_WIDTH-1:0] vec_a_reg;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0] vec_b_reg;
    logic                                 valid_a_reg;
    logic                                 valid_b_reg;
    logic                                 ready_a;
    logic                                 ready_b;
    logic                                 load_a;
    logic                                 load_b;

    assign ready_b  = !valid_b_reg || ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign load_a   = up_valid && ready_a;
    assign load_b   = valid_a_reg && ready_b;
    assign up_ready = ready_a;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        logic [NUM_TERMS-1:0][PROD_W-1:0] t;
        logic [2:0][PART_W-1:0]           part_next;
        logic [2:0][PART_W-1:0]           part_reg;
        logic [SUM_W-1:0]                 total_next;
        logic [SUM_W-1:0]                 total_reg;

        assign t = terms[a];

        always_comb
        begin
            part_next[0] = $signed({t[TERM_SCALE][PROD_W-1], t[TERM_SCALE]})
                         - $signed({t[TERM_CROSS_SUB][PROD_W-1], t[TERM_CROSS_SUB]});
            part_next[1] = $signed({t[TERM_CROSS_ADD][PROD_W-1], t[TERM_CROSS_ADD]})
                         + $signed({t[TERM_DOT][PROD_W-1], t[TERM_DOT]});
            part_next[2] = $signed({t[TERM_DOT + 1][PROD_W-1], t[TERM_DOT + 1]})
                         + $signed({t[TERM_DOT + 2][PROD_W-1], t[TERM_DOT + 2]});
        end

        assign total_next = $signed({{2{part_reg[0][PART_W-1]}}, part_reg[0]})
                          + $signed({{2{part_reg[1][PART_W-1]}}, part_reg[1]})
                          + $signed({{2{part_reg[2][PART_W-1]}}, part_reg[2]});

        always_ff @(posedge clk)
        begin
            if (load_a)
            begin
                part_reg <= part_next;
            end
            if (load_b)
            begin
                total_reg <= total_next;
            end
        end

        assign total[a] = total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= up_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            vec_a_reg <= vec;
        end
        if (load_b)
        begin
            vec_b_reg <= vec_a_reg;
        end
    end

    assign valid   = valid_b_reg;
    assign vec_out = vec_b_reg;

endmodule

// File: hw/rtl/qirv_round_sat.sv
module qirv_round_sat
    import qirv_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int QUAT_FRAC_BITS = 14
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   up_valid,
    output logic                                   up_ready,
    input  logic [NUM_AXES-1:0][3*DATA_WIDTH+2:0] total,
    input  logic [NUM_AXES-1:0][DATA_WIDTH-1:0]   vec,
    qirv_result_if.source                          result
);

    localparam int SUM_W = 3 * DATA_WIDTH + 3;
    localparam int FRAC2 = 2 * QUAT_FRAC_BITS;
    localparam int ACC_W = ((SUM_W + 1 > DATA_WIDTH + FRAC2) ? SUM_W + 1
                                                              : DATA_WIDTH + FRAC2) + 2;
    localparam logic [ACC_W-1:0]      HALF    = ACC_W'(1) << (FRAC2 - 1);
    localparam logic [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [NUM_AXES-1:0][DATA_WIDTH-1:0] out_next;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0] out_reg;
    logic [NUM_AXES-1:0]                  clip_next;
    logic                                 saturated_reg;
    logic                                 valid_reg;
    logic                                 load;

    assign up_ready = !valid_reg || result.ready;
    assign load     = up_valid && up_ready;

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        logic [ACC_W-1:0]              total_ext;
        logic [ACC_W-1:0]              vec_scaled;
        logic [ACC_W-1:0]              acc;
        logic [ACC_W-1:0]              shifted;
        logic [ACC_W-DATA_WIDTH:0]     upper;
        logic                          fits;

        assign total_ext  = {{(ACC_W - SUM_W){total[a][SUM_W-1]}}, total[a]};
        assign vec_scaled = {{(ACC_W - DATA_WIDTH){vec[a][DATA_WIDTH-1]}}, vec[a]} << FRAC2;
        assign acc        = (total_ext << 1) - vec_scaled + HALF;
        assign shifted    = $signed(acc) >>> FRAC2;
        assign upper      = shifted[ACC_W-1:DATA_WIDTH-1];
        assign fits       = (&upper) || !(|upper);

        always_comb
        begin
            if (fits)
            begin
                out_next[a] = shifted[DATA_WIDTH-1:0];
            end
            else if (acc[ACC_W-1])
            begin
                out_next[a] = OUT_MIN;
            end
            else
            begin
                out_next[a] = OUT_MAX;
            end
            clip_next[a] = !fits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg       <= out_next;
            saturated_reg <= |clip_next;
        end
    end

    assign result.valid     = valid_reg;
    assign result.out_x     = out_reg[AXIS_X];
    assign result.out_y     = out_reg[AXIS_Y];
    assign result.out_z     = out_reg[AXIS_Z];
    assign result.saturated = saturated_reg;

endmodule

// File: hw/rtl/quaternion_inverse_rotate_vector.sv
// Inverse quaternion rotation of a 3-vector.
// sample channel: one beat carries quat_w/x/y/z (signed, QUAT_FRAC_BITS fraction
// bits) and vec_x/y/z (signed, any scale). result channel: one beat per sample
// beat with out_x/y/z in the scale of the vector, rounded half up and clipped to
// DATA_WIDTH bits, and saturated set when any component was clipped.
// The sample beat passes to result.valid through five register stages (quaternion
// pair products, vector products, two adder levels, round and clip into the output
// register). Throughput: one beat per cycle while the receiver does not stall,
// each stage holding its own valid bit.
// Reset clears every valid bit; result.valid is low and sample.ready high after it.
// When the receiver stalls the result register holds its beat, the stages behind
// it fill up, and sample.ready drops once all five hold a beat. Nothing is dropped
// or repeated; a bubble in a stage is filled while the output waits.
module quaternion_inverse_rotate_vector
    import qirv_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int QUAT_FRAC_BITS = 14
)
(
    input  logic           clk,
    input  logic           rst_n,
    qirv_sample_if.sink    sample,
    qirv_result_if.source  result
);

    logic                                                   pair_valid;
    logic                                                   pair_ready;
    logic [NUM_PAIRS-1:0][2*DATA_WIDTH-1:0]                pairs;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   pair_vec;

    logic                                                   term_valid;
    logic                                                   term_ready;
    logic [NUM_AXES-1:0][NUM_TERMS-1:0][3*DATA_WIDTH-1:0] terms;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   term_vec;

    logic                                                   sum_valid;
    logic                                                   sum_ready;
    logic [NUM_AXES-1:0][3*DATA_WIDTH+2:0]                 total;
    logic [NUM_AXES-1:0][DATA_WIDTH-1:0]                   sum_vec;

    qirv_pair_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_pair_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .valid  (pair_valid),
        .ready  (pair_ready),
        .pairs  (pairs),
        .vec    (pair_vec)
    );

    qirv_vec_mul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_vec_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pair_valid),
        .up_ready (pair_ready),
        .pairs    (pairs),
        .vec      (pair_vec),
        .valid    (term_valid),
        .ready    (term_ready),
        .terms    (terms),
        .vec_out  (term_vec)
    );

    qirv_sum #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_sum (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (term_valid),
        .up_ready (term_ready),
        .terms    (terms),
        .vec      (term_vec),
        .valid    (sum_valid),
        .ready    (sum_ready),
        .total    (total),
        .vec_out  (sum_vec)
    );

    qirv_round_sat #(
        .DATA_WIDTH     (DATA_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_round_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .total    (total),
        .vec      (sum_vec),
        .result   (result)
    );

endmodule

// File: hw/rtl/qirv_checker.sv
module qirv_checker #(
    parameter int DATA_WIDTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         sample_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic signed [DATA_WIDTH-1:0] out_x,
    input logic signed [DATA_WIDTH-1:0] out_y,
    input logic signed [DATA_WIDTH-1:0] out_z,
    input logic                         saturated
);

    localparam logic [DATA_WIDTH-1:0] OUT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] OUT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // an empty or draining output register lets the whole pipe move
    a_ready_when_drained: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!result_valid || result_ready) |-> sample_ready
    ) else $error("sample not ready while the result register can take a beat");

    a_idle_in_reset: assert property (
        @(posedge clk)
        !rst_n |-> !result_valid
    ) else $error("result valid during reset");

    a_saturated_at_limit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (out_x == OUT_MAX || out_x == OUT_MIN ||
             out_y == OUT_MAX || out_y == OUT_MIN ||
             out_z == OUT_MAX || out_z == OUT_MIN)
    ) else $error("saturated beat with no component at a limit");

    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(out_x) && $stable(out_y) &&
             $stable(out_z) && $stable(saturated))
    ) else $error("stalled result beat changed");

endmodule

bind quaternion_inverse_rotate_vector qirv_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_qirv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .out_x        (result.out_x),
    .out_y        (result.out_y),
    .out_z        (result.out_z),
    .saturated    (result.saturated)
);
